[sv/voxel_ray_traversal_assert.svh]
// ----------------------------------------------------------------------------
// voxel ray traversal assertion macros
// implication checks used by the ray traversal back end
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define VRT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VRT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define VRT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// shared types and constants of the voxel ray traversal block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vrt_pkg;

   localparam int POS_W    = 10;
   localparam int DIR_W    = 16;
   localparam int MAG_W    = 17;
   localparam int QUO_W    = 25;
   localparam int DIST_W   = 32;
   localparam int FRAC_W   = 10;
   localparam int ORG_W    = 15;
   localparam int DCNT_W   = 5;
   localparam logic [DCNT_W-1:0] DIV_LAST = 5'd24;
   localparam logic [DIST_W-1:0] SAT_DIST = 32'hFFFF_FFFF;
   localparam logic [FRAC_W:0]   ONE_Q10  = 11'd1024;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
   localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

   localparam logic [ORG_W-1:0] ORIGIN_X_RST = 15'd22528;
   localparam logic [12:0]      ORIGIN_Y_RST = 13'd0;
   localparam logic [ORG_W-1:0] ORIGIN_Z_RST = 15'd12288;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [4:0]         cell_x;
      logic [2:0]         cell_y;
      logic [4:0]         cell_z;
      logic               cell_solid;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
   } item_type;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_SIDE  = 6'b001000,
      S_WALK  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

endpackage

[sv/vrt_ram.sv]
// ----------------------------------------------------------------------------
// vrt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vrt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/vrt_front.sv]
// ----------------------------------------------------------------------------
// vrt_front
// accepts items, decodes the function and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vrt_front import vrt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [4:0]              req_cell_x,
   input  logic [2:0]              req_cell_y,
   input  logic [4:0]              req_cell_z,
   input  logic                    req_cell_solid,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_dir_z,
   output logic                    q_valid,
   output item_type                q_item,
   input  logic                    q_pop
);

   item_type   ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item;
   logic       push;

   always_comb begin
      item.op         = req_func ? OP_CAST : OP_WRITE;
      item.cell_x     = req_cell_x;
      item.cell_y     = req_cell_y;
      item.cell_z     = req_cell_z;
      item.cell_solid = req_cell_solid;
      item.dir_x      = req_dir_x;
      item.dir_y      = req_dir_y;
      item.dir_z      = req_dir_z;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = ent_ff[rptr_ff];

   always_comb begin
      wptr_in = push  ? ~wptr_ff : wptr_ff;
      rptr_in = q_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         ent_ff[wptr_ff] <= item;
      end
   end

endmodule

[sv/vrt_back.sv]
// ----------------------------------------------------------------------------
// vrt_back
// grid store, reciprocal setup and cell walk with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_ray_traversal_assert.svh"
module vrt_back import vrt_pkg::*; #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 8,
   parameter int GRID_Z = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   input  logic [ORG_W-1:0] origin_x,
   input  logic [12:0]      origin_y,
   input  logic [ORG_W-1:0] origin_z,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_hit,
   output logic [1:0]       rsp_hit_face,
   output logic [4:0]       rsp_hit_x,
   output logic [2:0]       rsp_hit_y,
   output logic [4:0]       rsp_hit_z
);

   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);
   localparam int AW = XW + YW + ZW;
   localparam logic signed [POS_W-1:0] LIM [3] =
      '{POS_W'(GRID_X), POS_W'(GRID_Y), POS_W'(GRID_Z)};

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic [MAG_W-1:0]         rem_ff [3];
   logic [MAG_W-1:0]         rem_in [3];
   logic [QUO_W-1:0]         quo_ff [3];
   logic [QUO_W-1:0]         quo_in [3];
   logic [MAG_W-1:0]         mag_ff [3];
   logic [MAG_W-1:0]         mag_in [3];
   logic                     neg_ff [3];
   logic                     neg_in [3];
   logic [DIST_W-1:0]        side_ff [3];
   logic [DIST_W-1:0]        side_in [3];
   logic [DIST_W-1:0]        delta_ff [3];
   logic [DIST_W-1:0]        delta_in [3];
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [POS_W-1:0]  pos_in [3];
   logic [1:0]               face_ff, face_in;
   logic                     pend_ff, pend_in;
   logic                     res_hit_ff, res_hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff;
   logic [1:0]               rsp_face_ff;
   logic [4:0]               rsp_x_ff;
   logic [2:0]               rsp_y_ff;
   logic [4:0]               rsp_z_ff;
   logic                     rsp_load;

   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic                     ram_wdata;
   logic                     ram_re;
   logic [AW-1:0]            ram_raddr;
   logic                     ram_rdata;

   logic [ORG_W-1:0]         org [3];
   logic signed [DIR_W-1:0]  dirs [3];

   function automatic logic [AW-1:0] cell_addr(input logic signed [POS_W-1:0] x,
                                               input logic signed [POS_W-1:0] y,
                                               input logic signed [POS_W-1:0] z);
      return {x[XW-1:0], y[YW-1:0], z[ZW-1:0]};
   endfunction

   assign org[0]  = origin_x;
   assign org[1]  = {2'b00, origin_y};
   assign org[2]  = origin_z;
   assign dirs[0] = q_item.dir_x;
   assign dirs[1] = q_item.dir_y;
   assign dirs[2] = q_item.dir_z;
   assign ram_re  = (state_ff == S_WALK);

   always_comb begin
      logic signed [POS_W-1:0] wx, wy, wz, npos;
      logic signed [POS_W-1:0] wp [3];
      logic [MAG_W-1:0]        sdir, trial;
      logic [FRAC_W:0]         f;
      logic [35:0]             prod;
      logic [DIST_W:0]         sum;
      logic [1:0]              sel;

      state_in     = state_ff;
      clr_in       = clr_ff;
      dcnt_in      = dcnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      side_in      = side_ff;
      delta_in     = delta_ff;
      pos_in       = pos_ff;
      face_in      = face_ff;
      pend_in      = pend_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = 1'b0;
      ram_raddr    = cell_addr(pos_ff[0], pos_ff[1], pos_ff[2]);
      wx           = POS_W'(q_item.cell_x);
      wy           = POS_W'(q_item.cell_y);
      wz           = POS_W'(q_item.cell_z);
      npos         = '0;
      sdir         = '0;
      trial        = '0;
      f            = '0;
      prod         = '0;
      sum          = '0;
      sel          = AXIS_X;
      wp           = pos_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_WRITE) begin
                  if (wx < LIM[0] && wy < LIM[1] && wz < LIM[2]) begin
                     ram_we    = 1'b1;
                     ram_waddr = cell_addr(wx, wy, wz);
                     ram_wdata = q_item.cell_solid;
                  end
               end else begin
                  for (int a = 0; a < 3; a++) begin
                     sdir      = {dirs[a][DIR_W-1], dirs[a]};
                     neg_in[a] = dirs[a][DIR_W-1];
                     mag_in[a] = dirs[a][DIR_W-1] ? (MAG_W'(0) - sdir) : sdir;
                     rem_in[a] = '0;
                     quo_in[a] = '0;
                     pos_in[a] = POS_W'(org[a] >> FRAC_W);
                  end
                  dcnt_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            for (int a = 0; a < 3; a++) begin
               trial = {rem_ff[a][MAG_W-2:0], (dcnt_ff == '0)};
               if (trial >= mag_ff[a]) begin
                  rem_in[a] = trial - mag_ff[a];
                  quo_in[a] = {quo_ff[a][QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[a] = trial;
                  quo_in[a] = {quo_ff[a][QUO_W-2:0], 1'b0};
               end
            end
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DIV_LAST) begin
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            for (int a = 0; a < 3; a++) begin
               f    = neg_ff[a] ? {1'b0, org[a][FRAC_W-1:0]}
                                : (ONE_Q10 - {1'b0, org[a][FRAC_W-1:0]});
               prod = 36'(f) * 36'(quo_ff[a]);
               if (mag_ff[a] == '0) begin
                  delta_in[a] = SAT_DIST;
                  side_in[a]  = SAT_DIST;
               end else begin
                  delta_in[a] = DIST_W'(quo_ff[a]);
                  side_in[a]  = DIST_W'(prod >> FRAC_W);
               end
            end
            pend_in = 1'b0;
            if (pos_ff[0] >= LIM[0] || pos_ff[1] >= LIM[1] || pos_ff[2] >= LIM[2]) begin
               res_hit_in = 1'b0;
               state_in   = S_EMIT;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (pend_ff && ram_rdata) begin
               res_hit_in = 1'b1;
               pend_in    = 1'b0;
               state_in   = S_EMIT;
            end else begin
               if (side_ff[0] < side_ff[1]) begin
                  sel = (side_ff[0] < side_ff[2]) ? AXIS_X : AXIS_Z;
               end else begin
                  sel = (side_ff[1] < side_ff[2]) ? AXIS_Y : AXIS_Z;
               end
               sum          = {1'b0, side_ff[sel]} + {1'b0, delta_ff[sel]};
               side_in[sel] = sum[DIST_W] ? SAT_DIST : sum[DIST_W-1:0];
               npos         = neg_ff[sel] ? (pos_ff[sel] - POS_W'(1))
                                          : (pos_ff[sel] + POS_W'(1));
               if (npos < 0 || npos >= LIM[sel]) begin
                  res_hit_in = 1'b0;
                  pend_in    = 1'b0;
                  state_in   = S_EMIT;
               end else begin
                  wp[sel]     = npos;
                  pos_in[sel] = npos;
                  face_in     = sel;
                  pend_in     = 1'b1;
                  ram_raddr   = cell_addr(wp[0], wp[1], wp[2]);
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      side_ff    <= side_in;
      delta_ff   <= delta_in;
      pos_ff     <= pos_in;
      face_ff    <= face_in;
      res_hit_ff <= res_hit_in;
      if (rsp_load) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_face_ff <= res_hit_ff ? face_ff : 2'd0;
         rsp_x_ff    <= res_hit_ff ? pos_ff[0][4:0] : 5'd0;
         rsp_y_ff    <= res_hit_ff ? pos_ff[1][2:0] : 3'd0;
         rsp_z_ff    <= res_hit_ff ? pos_ff[2][4:0] : 5'd0;
      end
   end

   vrt_ram #(
      .WIDTH (1),
      .DEPTH (2 ** AW)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_hit_face = rsp_face_ff;
   assign rsp_hit_x    = rsp_x_ff;
   assign rsp_hit_y    = rsp_y_ff;
   assign rsp_hit_z    = rsp_z_ff;

   `VRT_ASSERT_IMPLY(a_pend_only_walk, clock, reset, pend_ff, state_ff == S_WALK)
   `VRT_ASSERT_IMPLY(a_pop_only_idle, clock, reset, q_pop, state_ff == S_IDLE)
   `VRT_ASSERT_NEXT(a_emit_loads_out, clock, reset, rsp_load, rsp_valid_ff && state_ff == S_IDLE)

endmodule

[sv/voxel_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// 3d dda voxel traversal over an occupancy grid with apb origin registers
// ----------------------------------------------------------------------------
// write item: handled in the idle state of the back end after the queue, no result
// cast item: pop, divider, side setup, one walk step per cell walked, then emit into the output register, one at a time
// walk rate set by the single grid ram read port, one cell per cycle
// reset clears control state, then sweeps all 2**(clog2 gx + clog2 gy + clog2 gz) grid ram
// addresses (8192 by default) to empty before taking items
`timescale 1ns / 1ps
module voxel_ray_traversal import vrt_pkg::*; #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 8,
   parameter int GRID_Z = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [4:0]              req_cell_x,
   input  logic [2:0]              req_cell_y,
   input  logic [4:0]              req_cell_z,
   input  logic                    req_cell_solid,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_dir_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic [1:0]              rsp_hit_face,
   output logic [4:0]              rsp_hit_x,
   output logic [2:0]              rsp_hit_y,
   output logic [4:0]              rsp_hit_z,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [ORG_W-1:0] origin_x_ff, origin_x_in;
   logic [12:0]      origin_y_ff, origin_y_in;
   logic [ORG_W-1:0] origin_z_ff, origin_z_in;
   logic             csr_wr;
   logic [1:0]       csr_idx;
   logic             q_valid;
   logic             q_pop;
   item_type         q_item;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      origin_z_in = origin_z_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_ORIGIN_X: origin_x_in = pwdata[ORG_W-1:0];
            REG_ORIGIN_Y: origin_y_in = pwdata[12:0];
            REG_ORIGIN_Z: origin_z_in = pwdata[ORG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ORIGIN_X: prdata = 32'(origin_x_ff);
         REG_ORIGIN_Y: prdata = 32'(origin_y_ff);
         REG_ORIGIN_Z: prdata = 32'(origin_z_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_X_RST;
         origin_y_ff <= ORIGIN_Y_RST;
         origin_z_ff <= ORIGIN_Z_RST;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         origin_z_ff <= origin_z_in;
      end
   end

   vrt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_z     (req_cell_z),
      .req_cell_solid (req_cell_solid),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   vrt_back #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .origin_z     (origin_z_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_hit      (rsp_hit),
      .rsp_hit_face (rsp_hit_face),
      .rsp_hit_x    (rsp_hit_x),
      .rsp_hit_y    (rsp_hit_y),
      .rsp_hit_z    (rsp_hit_z)
   );

endmodule
